FILE: rtl/acfr_pkg.sv
// Package for the associative cache with FIFO replacement.
// Holds the beat types, the tag store control and compare result structs, and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acfr_pkg;

	localparam int SLOTS_DEF  = 8;
	localparam int KEY_W      = 32;
	localparam int AGE_W      = 32;
	localparam int CMP_W      = 32;
	localparam int SLOT_W     = 3;
	localparam int ADDR_MAX_W = 6;
	localparam int CFG_W      = 4;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [CFG_W-1:0] ENTRIES_RST = 4'd8;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INVAL  = 1'b1;

	localparam logic REG_ENTRIES = 1'b0;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key;
	} in_beat_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              error;
	} out_beat_t;

	typedef struct packed {
		logic                  clr;
		logic                  wr_en;
		logic [ADDR_MAX_W-1:0] addr;
		logic [KEY_W-1:0]      key;
		logic [AGE_W-1:0]      age;
	} store_ctl_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/assoc_cache_fifo_replace_unit.sv
// Channel    Ports                                   Beat marker
// request    req (in_beat_t)                         start && !busy
// result     rsp (out_beat_t)                        done, one cycle, no stall
// config     psel penable pwrite paddr pwdata prdata psel && penable && pwrite
//
// An invalidate or a zero-key lookup returns its result in the cycle after acceptance.
// A lookup reads one tag store entry per cycle through a single read port and judges it
// with the shared compare unit: a hit on the last used slot ends in the fast check, a hit
// at scan slot i ends the key scan, and a miss then scans the ages of the n slots in use and refills the oldest.
// Reset clears every entry at once through the valid bits; no clearing pass is needed.
// Depends on acfr_pkg, acfr_tag_store and acfr_cmp_unit.
`timescale 1ns / 1ps
`default_nettype none

module assoc_cache_fifo_replace_unit
	import acfr_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire in_beat_t           req,
	output logic                    done,
	output out_beat_t               rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FAST  = 3'd1;
	localparam logic [2:0] S_KSCAN = 3'd2;
	localparam logic [2:0] S_ASCAN = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] entries_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] n_d;
	logic [IDX_W-1:0] last_slot_q;
	logic             last_valid_q;
	logic [AGE_W-1:0] fill_q;
	logic [AGE_W-1:0] stamp;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [AGE_W-1:0] best_age_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [KEY_W-1:0] rd_key;
	logic [AGE_W-1:0] rd_age;
	logic [CMP_W-1:0] op_a;
	logic [CMP_W-1:0] op_b;
	cmp_res_t         cmp;
	store_ctl_t       st_ctl;
	out_beat_t        rsp_q;
	logic             done_q;
	logic             accept;
	logic             cfg_wr;
	logic             fast_hit;
	logic             scan_last;

	// Configuration register.

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RST;
		end else if (cfg_wr && paddr[2] == REG_ENTRIES) begin
			entries_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ENTRIES: prdata = PDATA_W'(entries_q);
			default:     prdata = '0;
		endcase
	end

	always_comb begin
		if (entries_q == '0) begin
			n_d = CNT_W'(1);
		end else if (int'(entries_q) > SLOTS) begin
			n_d = CNT_W'(SLOTS);
		end else begin
			n_d = CNT_W'(entries_q);
		end
	end

	// Sequencer.

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign stamp     = fill_q + AGE_W'(1);
	assign fast_hit  = last_valid_q && (CNT_W'(last_slot_q) < n_q) && cmp.eq;
	assign scan_last = (CNT_W'(rd_idx_s1) == n_q - CNT_W'(1));

	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = last_slot_q;
			S_FAST:  rd_addr = '0;
			S_KSCAN: rd_addr = scan_last ? '0 : iss_q[IDX_W-1:0];
			S_ASCAN: rd_addr = iss_q[IDX_W-1:0];
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		if (state_q == S_ASCAN) begin
			op_a = rd_age;
			op_b = best_age_q;
		end else begin
			op_a = rd_key;
			op_b = key_q;
		end
	end

	always_comb begin
		st_ctl.clr   = accept && (req.mode == MODE_INVAL);
		st_ctl.wr_en = (state_q == S_WRITE);
		st_ctl.addr  = ADDR_MAX_W'(best_idx_q);
		st_ctl.key   = key_q;
		st_ctl.age   = stamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			iss_q        <= '0;
			last_slot_q  <= '0;
			last_valid_q <= 1'b0;
			fill_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.mode == MODE_INVAL) begin
							last_valid_q <= 1'b0;
							done_q       <= 1'b1;
						end else if (req.key == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_FAST;
						end
					end
				end
				S_FAST: begin
					if (fast_hit) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_KSCAN;
						iss_q   <= CNT_W'(1);
					end
				end
				S_KSCAN: begin
					if (cmp.eq) begin
						state_q      <= S_IDLE;
						done_q       <= 1'b1;
						last_slot_q  <= rd_idx_s1;
						last_valid_q <= 1'b1;
					end else if (scan_last) begin
						state_q <= S_ASCAN;
						iss_q   <= CNT_W'(1);
					end else begin
						iss_q <= iss_q + CNT_W'(1);
					end
				end
				S_ASCAN: begin
					if (scan_last) begin
						state_q <= S_WRITE;
					end else begin
						iss_q <= iss_q + CNT_W'(1);
					end
				end
				S_WRITE: begin
					state_q      <= S_IDLE;
					done_q       <= 1'b1;
					fill_q       <= stamp;
					last_slot_q  <= best_idx_q;
					last_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q       <= req.key;
					n_q         <= n_d;
					rsp_q.slot  <= '0;
					rsp_q.hit   <= 1'b0;
					rsp_q.error <= (req.mode == MODE_LOOKUP) && (req.key == '0);
				end
			end
			S_FAST: begin
				if (fast_hit) begin
					rsp_q.slot  <= SLOT_W'(last_slot_q);
					rsp_q.hit   <= 1'b1;
					rsp_q.error <= 1'b0;
				end
			end
			S_KSCAN: begin
				if (cmp.eq) begin
					rsp_q.slot  <= SLOT_W'(rd_idx_s1);
					rsp_q.hit   <= 1'b1;
					rsp_q.error <= 1'b0;
				end
			end
			S_ASCAN: begin
				// A strict less-than keeps the lowest slot among equal stamps.
				if (rd_idx_s1 == '0 || cmp.lt) begin
					best_idx_q <= rd_idx_s1;
					best_age_q <= rd_age;
				end
			end
			S_WRITE: begin
				rsp_q.slot  <= SLOT_W'(best_idx_q);
				rsp_q.hit   <= 1'b0;
				rsp_q.error <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	acfr_tag_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (st_ctl),
		.rd_addr(rd_addr),
		.rd_key (rd_key),
		.rd_age (rd_age)
	);

	acfr_cmp_unit u_cmp (
		.a  (op_a),
		.b  (op_b),
		.res(cmp)
	);

	// Checks.

	a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("Busy fell without a result beat.");

	a_inval_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.mode == MODE_INVAL) |=> (done && rsp == '0))
		else $error("Invalidate did not return an all-zero result in the next cycle.");

	a_zero_key_error: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.mode == MODE_LOOKUP && req.key == '0) |=> (done && rsp.error))
		else $error("Zero-key lookup did not flag an error in the next cycle.");

	a_hit_excludes_error: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.hit && rsp.error))
		else $error("Result beat carries both hit and error.");

endmodule

`default_nettype wire

FILE: rtl/acfr_cmp_unit.sv
// Shared compare unit: equality and unsigned less-than on one operand pair.
// Depends on acfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acfr_cmp_unit
	import acfr_pkg::*;
(
	input  wire logic [CMP_W-1:0] a,
	input  wire logic [CMP_W-1:0] b,
	output cmp_res_t              res
);

	always_comb begin
		res.eq = (a == b);
		res.lt = (a < b);
	end

endmodule

`default_nettype wire

FILE: rtl/acfr_tag_store.sv
// Tag store: key and age memories with one write and one registered read port, plus valid bits.
// An entry that is not valid reads as key zero and age zero. Depends on acfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acfr_tag_store
	import acfr_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire store_ctl_t               ctl,
	input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
	output logic      [KEY_W-1:0]         rd_key,
	output logic      [AGE_W-1:0]         rd_age
);

	localparam int IDX_W = $clog2(SLOTS);

	logic [KEY_W-1:0] key_mem [SLOTS];
	logic [AGE_W-1:0] age_mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [KEY_W-1:0] rd_key_q;
	logic [AGE_W-1:0] rd_age_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] wr_idx;

	assign wr_idx = ctl.addr[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			key_mem[wr_idx] <= ctl.key;
			age_mem[wr_idx] <= ctl.age;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_age_q <= age_mem[rd_addr];
	end

	assign rd_key = rd_vld_q ? rd_key_q : '0;
	assign rd_age = rd_vld_q ? rd_age_q : '0;

endmodule

`default_nettype wire
